// ===== hdl/tdbb_pkg.sv =====
// Shared types, constants and the code decoder for the texel decode and bilinear blend block.
// No dependencies; every other file imports this package.
package tdbb_pkg;

    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int NUM_LANES            = 4;
    localparam int TEXEL_W              = 16;

    // Format modes carried with each item
    localparam logic [1:0] MODE_LUM    = 2'd0;
    localparam logic [1:0] MODE_LA     = 2'd1;
    localparam logic [1:0] MODE_CODE   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Code scheme register values
    localparam logic CODE_TRI_BINS = 1'b0;
    localparam logic CODE_BIN_ALPHA = 1'b1;

    // Codes at or above this value are on the opaque ramp in the triangular-bin scheme
    localparam logic [7:0] CODE_RAMP_START = 8'd120;

    // ceil(2^16 / 9); exact quotient for dividends below 2^12
    localparam logic [16:0] RECIP_NINE = 17'd7282;

    typedef struct packed {
        logic [7:0] lum;
        logic [7:0] alpha;
    } t_texel_la;

    // Pipeline control from the top level to each lane
    typedef struct packed {
        logic       en1;
        logic       en2;
        logic [1:0] mode;
        logic       code_version;
    } t_lane_ctl;

    // Decode one code byte into a luminance and an alpha byte.
    function automatic t_texel_la decode_code(input logic ver, input logic [7:0] c);
        t_texel_la   r;
        logic [3:0]  b;
        logic [7:0]  base;
        logic [7:0]  j;
        logic [11:0] p;
        logic [16:0] recip;
        logic [28:0] prod;
        logic [11:0] ramp;
        logic [7:0]  lin;
        r     = '0;
        b     = '0;
        base  = '0;
        recip = '0;
        prod  = '0;
        if (ver == CODE_TRI_BINS) begin
            if (c < CODE_RAMP_START) begin
                // bin index: largest k with k(k+1)/2 <= c
                for (int k = 1; k <= 14; k++) begin
                    if (c >= 8'((k * (k + 1)) / 2)) begin
                        b    = 4'(k);
                        base = 8'((k * (k + 1)) / 2);
                    end
                end
                j = c - base;
                p = {j[3:0], 1'b1, 7'b0};  // 128 * (2j + 1)
                // divide by b + 1: multiply by ceil(2^16 / (b + 1)), exact for p < 2^12
                case (b)
                    4'd0:    recip = 17'd65536;
                    4'd1:    recip = 17'd32768;
                    4'd2:    recip = 17'd21846;
                    4'd3:    recip = 17'd16384;
                    4'd4:    recip = 17'd13108;
                    4'd5:    recip = 17'd10923;
                    4'd6:    recip = 17'd9363;
                    4'd7:    recip = 17'd8192;
                    4'd8:    recip = 17'd7282;
                    4'd9:    recip = 17'd6554;
                    4'd10:   recip = 17'd5958;
                    4'd11:   recip = 17'd5462;
                    4'd12:   recip = 17'd5042;
                    4'd13:   recip = 17'd4682;
                    4'd14:   recip = 17'd4370;
                    default: recip = '0;
                endcase
                prod    = 29'(p) * 29'(recip);
                r.lum   = prod[23:16];
                r.alpha = {b, 4'b0000} + {4'b0000, b};  // 17 * b
            end else begin
                ramp    = 12'(c - CODE_RAMP_START) * 12'd17;
                prod    = 29'(ramp) * 29'(RECIP_NINE);
                r.lum   = prod[23:16];
                r.alpha = 8'd255;
            end
        end else begin
            if (c != 8'd0) begin
                // 255 (c - 1) / 254 floors to c - 1, except the top code reaches 255
                lin     = c - 8'd1;
                r.lum   = (c == 8'd255) ? 8'd255 : lin;
                r.alpha = 8'd255;
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/tdbb_if.sv =====
// Channel interfaces: sample input, blended result and code scheme register write.
// Depends on tdbb_pkg for widths.
interface tdbb_in_if import tdbb_pkg::*; #(parameter int WFB = WEIGHT_FRAC_BITS_DEF);
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [TEXEL_W-1:0] texel_0;
    logic [TEXEL_W-1:0] texel_1;
    logic [TEXEL_W-1:0] texel_2;
    logic [TEXEL_W-1:0] texel_3;
    logic [WFB:0]       weight_0;
    logic [WFB:0]       weight_1;
    logic [WFB:0]       weight_2;
    logic [WFB:0]       weight_3;
    modport source (output valid, mode, texel_0, texel_1, texel_2, texel_3,
                    weight_0, weight_1, weight_2, weight_3, input ready);
    modport sink   (input valid, mode, texel_0, texel_1, texel_2, texel_3,
                    weight_0, weight_1, weight_2, weight_3, output ready);
endinterface

interface tdbb_out_if import tdbb_pkg::*; #(parameter int WFB = WEIGHT_FRAC_BITS_DEF);
    logic          valid;
    logic          ready;
    logic [WFB+9:0] luminance_sum;
    logic [WFB+9:0] alpha_sum;
    modport source (output valid, luminance_sum, alpha_sum, input ready);
    modport sink   (input valid, luminance_sum, alpha_sum, output ready);
endinterface

interface tdbb_cfg_if;
    logic valid;
    logic ready;
    logic code_version;
    modport source (output valid, code_version, input ready);
    modport sink   (input valid, code_version, output ready);
endinterface

// ===== hdl/tdbb_lane.sv =====
// One blend lane: decodes a texel, then multiplies luminance and alpha by the weight.
// Depends on tdbb_pkg (decode_code, t_lane_ctl).
module tdbb_lane import tdbb_pkg::*; #(
    parameter int WFB = WEIGHT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  t_lane_ctl          i_ctl,
    input  logic [TEXEL_W-1:0] i_texel,
    input  logic [WFB:0]       i_weight,
    output logic [WFB+8:0]     o_lum_prod,
    output logic [WFB+8:0]     o_alpha_prod
);

    t_texel_la      n_la;
    t_texel_la      r_la;
    logic [WFB:0]   r_weight;
    logic [WFB+8:0] r_lum_prod;
    logic [WFB+8:0] r_alpha_prod;

    always_comb begin
        n_la = '0;
        case (i_ctl.mode)
            MODE_LUM:  n_la.lum = i_texel[7:0];
            MODE_LA:   n_la = '{lum: i_texel[7:0], alpha: i_texel[15:8]};
            MODE_CODE: n_la = decode_code(i_ctl.code_version, i_texel[7:0]);
            default:   n_la = '0;  // unused mode blends to zero
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_la     <= n_la;
            r_weight <= i_weight;
        end
        if (i_ctl.en2) begin
            r_lum_prod   <= (WFB + 9)'(r_weight) * (WFB + 9)'(r_la.lum);
            r_alpha_prod <= (WFB + 9)'(r_weight) * (WFB + 9)'(r_la.alpha);
        end
    end

    assign o_lum_prod   = r_lum_prod;
    assign o_alpha_prod = r_alpha_prod;

endmodule

// ===== hdl/tdbb_merge.sv =====
// Merging stage: adds the lane products, rounds the code-mode alpha, saturates, registers.
// Depends on tdbb_pkg for lane count and mode codes.
module tdbb_merge import tdbb_pkg::*; #(
    parameter int WFB = WEIGHT_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [1:0]     i_mode,
    input  logic [WFB+8:0] i_lum_prod   [NUM_LANES],
    input  logic [WFB+8:0] i_alpha_prod [NUM_LANES],
    output logic [WFB+9:0] o_lum_sum,
    output logic [WFB+9:0] o_alpha_sum,
    output logic [1:0]     o_mode
);

    localparam logic [WFB+10:0] SumMax  = (WFB + 11)'(1020) << WFB;
    localparam logic [WFB+10:0] RoundUp = (WFB + 11)'(1) << (WFB - 1);

    logic [WFB+10:0] w_lsum;
    logic [WFB+10:0] w_asum;
    logic [WFB+10:0] w_around;
    logic [WFB+10:0] w_asel;
    logic [WFB+9:0]  r_lum_sum;
    logic [WFB+9:0]  r_alpha_sum;
    logic [1:0]      r_mode;

    always_comb begin
        w_lsum = '0;
        w_asum = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            w_lsum = w_lsum + (WFB + 11)'(i_lum_prod[i]);
            w_asum = w_asum + (WFB + 11)'(i_alpha_prod[i]);
        end
        w_around = w_asum + RoundUp;
        w_asel   = (i_mode == MODE_CODE) ? {w_around[WFB+10:WFB], WFB'(0)} : w_asum;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lum_sum   <= (w_lsum > SumMax) ? SumMax[WFB+9:0] : w_lsum[WFB+9:0];
            r_alpha_sum <= (w_asel > SumMax) ? SumMax[WFB+9:0] : w_asel[WFB+9:0];
            r_mode      <= i_mode;
        end
    end

    assign o_lum_sum   = r_lum_sum;
    assign o_alpha_sum = r_alpha_sum;
    assign o_mode      = r_mode;

endmodule

// ===== hdl/la_texel_decode_bilinear_blend.sv =====
// Registered stages from input accept to result valid, in order: decode, multiply, sum.
// Throughput: one item per cycle; the multipliers of the four lanes and the adder tree each
// take one item a cycle, each stage holds while the stage after it is full and stalled.
// Reset (i_rst_n low, synchronous) clears the stage valid flags and the code scheme
// register; datapath registers are not reset.
module la_texel_decode_bilinear_blend import tdbb_pkg::*; #(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdbb_cfg_if.sink    i_cfg,
    tdbb_in_if.sink     i_px,
    tdbb_out_if.source  o_res
);

    localparam int WFB = WEIGHT_FRAC_BITS;

    // Code scheme register; user must write it only while idle (not enforced), so no hazard with items in flight
    logic r_code_version;

    // Stage valid flags: 1 = decoded, 2 = products, 3 = output register
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic [1:0] r_mode1;
    logic [1:0] r_mode2;

    logic w_en1;
    logic w_en2;
    logic w_en3;

    t_lane_ctl          w_ctl;
    logic [TEXEL_W-1:0] w_texel      [NUM_LANES];
    logic [WFB:0]       w_weight     [NUM_LANES];
    logic [WFB+8:0]     w_lum_prod   [NUM_LANES];
    logic [WFB+8:0]     w_alpha_prod [NUM_LANES];
    logic [1:0]         w_out_mode;

    // A stage loads when it is empty or its contents move on this cycle
    assign w_en3 = !r_v3 || o_res.ready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign i_px.ready  = w_en1;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_version <= CODE_TRI_BINS;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_code_version <= i_cfg.code_version;
            end
            if (w_en1) begin
                r_v1 <= i_px.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Mode travels beside the lanes for rounding in the merge
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_mode1 <= i_px.mode;
        end
        if (w_en2) begin
            r_mode2 <= r_mode1;
        end
    end

    assign w_ctl = '{en1: w_en1, en2: w_en2, mode: i_px.mode, code_version: r_code_version};

    assign w_texel[0]  = i_px.texel_0;
    assign w_texel[1]  = i_px.texel_1;
    assign w_texel[2]  = i_px.texel_2;
    assign w_texel[3]  = i_px.texel_3;
    assign w_weight[0] = i_px.weight_0;
    assign w_weight[1] = i_px.weight_1;
    assign w_weight[2] = i_px.weight_2;
    assign w_weight[3] = i_px.weight_3;

    // One lane per texel of the 2x2 footprint
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        tdbb_lane #(.WFB(WFB)) u_lane (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_texel      (w_texel[g]),
            .i_weight     (w_weight[g]),
            .o_lum_prod   (w_lum_prod[g]),
            .o_alpha_prod (w_alpha_prod[g])
        );
    end

    tdbb_merge #(.WFB(WFB)) u_merge (
        .i_clk        (i_clk),
        .i_en         (w_en3),
        .i_mode       (r_mode2),
        .i_lum_prod   (w_lum_prod),
        .i_alpha_prod (w_alpha_prod),
        .o_lum_sum    (o_res.luminance_sum),
        .o_alpha_sum  (o_res.alpha_sum),
        .o_mode       (w_out_mode)
    );

    // Checks
    localparam logic [WFB+9:0] OutMax = (WFB + 10)'(1020) << WFB;

    a_lum_mode_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && (w_out_mode == MODE_LUM || w_out_mode == MODE_UNUSED)
        |-> o_res.alpha_sum == '0)
        else $error("alpha sum not zero in luminance-only or unused mode");

    a_code_alpha_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && w_out_mode == MODE_CODE |-> o_res.alpha_sum[WFB-1:0] == '0)
        else $error("code-mode alpha sum has fraction bits");

    a_sum_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> o_res.luminance_sum <= OutMax && o_res.alpha_sum <= OutMax)
        else $error("result above saturation limit");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_px.valid && i_px.ready |=> r_v1)
        else $error("accepted item lost before decode stage");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for la_texel_decode_bilinear_blend: directed and random texel items,
// predicted in-bench and checked in order. Depends on tdbb_pkg, the tdbb interfaces and the RTL.
module tb;
    import tdbb_pkg::*;

    localparam int WFB = WEIGHT_FRAC_BITS_DEF;
    localparam logic [WFB:0] W_ONE = (WFB + 1)'(1) << WFB;
    localparam logic [WFB:0] W_MAX = '1;
    localparam longint unsigned SUM_CAP = 64'd1020 << WFB;
    localparam longint unsigned HALF_LSB = 64'd1 << (WFB - 1);

    // One input item: mode plus four texels and four weights, lane 0 in the low slice
    typedef struct packed {
        logic [1:0]               mode;
        logic [3:0][TEXEL_W-1:0]  texel;
        logic [3:0][WFB:0]        weight;
    } px_item_t;

    // One blended result
    typedef struct packed {
        logic [WFB+9:0] lum;
        logic [WFB+9:0] alpha;
    } blend_sum_t;

    typedef enum int {RX_FREE, RX_CHOPPY, RX_STALLS} rx_regime_t;

    logic clk = 1'b0;
    logic rst_n;

    tdbb_in_if  #(.WFB(WFB)) px_if ();
    tdbb_out_if #(.WFB(WFB)) res_if ();
    tdbb_cfg_if              cfg_if ();

    la_texel_decode_bilinear_blend #(.WEIGHT_FRAC_BITS(WFB)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if.sink),
        .i_px    (px_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bench copy of the code scheme register, updated when a write is accepted
    logic        scheme_now = CODE_TRI_BINS;
    blend_sum_t  blend_q[$];
    int          errors = 0;
    int          n_checked = 0;
    int          mode_seen[4] = '{0, 0, 0, 0};
    int          code_seen[2] = '{0, 0};
    int          burst_left = 0;

    // ------------------------------------------------------------------
    // Predictor: decode (mode 2 only), weight, sum, round and saturate.
    // ------------------------------------------------------------------
    function automatic blend_sum_t predict_blend(input px_item_t it, input logic scheme);
        longint unsigned lum_acc;
        longint unsigned alpha_acc;
        longint unsigned w;
        int unsigned l;
        int unsigned a;
        int unsigned c;
        int unsigned b;
        int unsigned j;
        blend_sum_t r;
        lum_acc   = 0;
        alpha_acc = 0;
        if (it.mode != MODE_UNUSED) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                w = 64'(it.weight[i]);
                l = 32'(it.texel[i][7:0]);
                a = 32'(it.texel[i][15:8]);
                if (it.mode == MODE_CODE) begin
                    c = l;
                    if (scheme == CODE_TRI_BINS) begin
                        if (c < 32'(CODE_RAMP_START)) begin
                            // bin b: largest with b(b+1)/2 <= c, j is the offset in the bin
                            b = 0;
                            while (b < 14 && (b + 1) * (b + 2) / 2 <= c)
                                b++;
                            j = c - b * (b + 1) / 2;
                            l = 128 * (2 * j + 1) / (b + 1);
                            a = 17 * b;
                        end else begin
                            l = 17 * (c - 32'(CODE_RAMP_START)) / 9;
                            a = 255;
                        end
                    end else if (c == 0) begin
                        l = 0;
                        a = 0;
                    end else begin
                        l = 255 * (c - 1) / 254;
                        a = 255;
                    end
                end
                lum_acc += w * 64'(l);
                if (it.mode != MODE_LUM)
                    alpha_acc += w * 64'(a);
            end
            // decoded alpha rounds half up to a whole number
            if (it.mode == MODE_CODE)
                alpha_acc = ((alpha_acc + HALF_LSB) >> WFB) << WFB;
            if (lum_acc > SUM_CAP)
                lum_acc = SUM_CAP;
            if (alpha_acc > SUM_CAP)
                alpha_acc = SUM_CAP;
        end
        r.lum   = lum_acc[WFB+9:0];
        r.alpha = alpha_acc[WFB+9:0];
        return r;
    endfunction

    function automatic px_item_t make_px(
        input logic [1:0] mode,
        input logic [15:0] t0, input logic [15:0] t1,
        input logic [15:0] t2, input logic [15:0] t3,
        input logic [WFB:0] w0, input logic [WFB:0] w1,
        input logic [WFB:0] w2, input logic [WFB:0] w3);
        px_item_t it;
        it.mode   = mode;
        it.texel  = {t3, t2, t1, t0};
        it.weight = {w3, w2, w1, w0};
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Monitor at the rising edge: check results first, then log accepted
    // items. A result can never stem from an item accepted at the same
    // edge, so this order is safe and keeps push/pop in one process.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        blend_sum_t want;
        px_item_t   got_px;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (blend_q.size() == 0) begin
                $display("%0t: result with nothing expected: luminance_sum %0d alpha_sum %0d",
                         $time, res_if.luminance_sum, res_if.alpha_sum);
                errors++;
            end else begin
                want = blend_q.pop_front();
                n_checked++;
                if (res_if.luminance_sum !== want.lum) begin
                    $display("%0t: luminance_sum mismatch: expected %0d, actual %0d",
                             $time, want.lum, res_if.luminance_sum);
                    errors++;
                end
                if (res_if.alpha_sum !== want.alpha) begin
                    $display("%0t: alpha_sum mismatch: expected %0d, actual %0d",
                             $time, want.alpha, res_if.alpha_sum);
                    errors++;
                end
            end
        end
        if (rst_n && px_if.valid && px_if.ready) begin
            got_px.mode   = px_if.mode;
            got_px.texel  = {px_if.texel_3, px_if.texel_2, px_if.texel_1, px_if.texel_0};
            got_px.weight = {px_if.weight_3, px_if.weight_2, px_if.weight_1, px_if.weight_0};
            blend_q.push_back(predict_blend(got_px, scheme_now));
            mode_seen[got_px.mode]++;
            if (got_px.mode == MODE_CODE)
                code_seen[scheme_now]++;
        end
        if (rst_n && cfg_if.valid && cfg_if.ready)
            scheme_now = cfg_if.code_version;
    end

    // ------------------------------------------------------------------
    // Result side backpressure: regimes of free flow, choppy ready and
    // longer stalls, each regime picked at random.
    // ------------------------------------------------------------------
    rx_regime_t rx_regime = RX_FREE;
    int         rx_left = 0;
    int         stall_left = 0;

    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_regime = rx_regime_t'($urandom_range(0, 2));
            rx_left   = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_regime)
            RX_FREE: begin
                res_if.ready <= 1'b1;
            end
            RX_CHOPPY: begin
                res_if.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    res_if.ready <= 1'b0;
                end else if ($urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(0, 7);
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sender: items go out in bursts of 1..24 with optional idle gaps between bursts.
    // Valid stays high across a burst; the task returns at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_px(input px_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                @(negedge clk);
                px_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        px_if.mode     = it.mode;
        px_if.texel_0  = it.texel[0];
        px_if.texel_1  = it.texel[1];
        px_if.texel_2  = it.texel[2];
        px_if.texel_3  = it.texel[3];
        px_if.weight_0 = it.weight[0];
        px_if.weight_1 = it.weight[1];
        px_if.weight_2 = it.weight[2];
        px_if.weight_3 = it.weight[3];
        px_if.valid    = 1'b1;
        do @(posedge clk); while (!px_if.ready);
    endtask

    // Stop sending and wait for every outstanding result; each item gives one.
    task automatic drain_results();
        @(negedge clk);
        px_if.valid = 1'b0;
        burst_left  = 0;
        while (blend_q.size() != 0)
            @(negedge clk);
    endtask

    // Register writes only with the pipe empty
    task automatic write_scheme(input logic scheme);
        drain_results();
        cfg_if.code_version = scheme;
        cfg_if.valid        = 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain luminance and luminance+alpha: zeros, full texels at unit weight
    // (sum lands exactly on the cap), over-unit weights, unnormalized weights.
    task automatic test_plain_extremes();
        write_scheme(CODE_TRI_BINS);
        send_px(make_px(MODE_LUM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0));
        send_px(make_px(MODE_LUM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        W_ONE, W_ONE, W_ONE, W_ONE));
        send_px(make_px(MODE_LA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        W_ONE, W_ONE, W_ONE, W_ONE));
        send_px(make_px(MODE_LA, 16'h00FF, 16'hFF00, 16'h8001, 16'h7F80,
                        16384, 16384, 16384, 16384));
        send_px(make_px(MODE_LA, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 1, 2, 3, 100000));
        send_px(make_px(MODE_LA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        W_MAX, W_MAX, W_MAX, W_MAX));
        // just under the cap
        send_px(make_px(MODE_LUM, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, W_MAX, W_MAX, 0, 0));
    endtask

    // Mode 3 returns zeros whatever the payload
    task automatic test_unused_mode();
        send_px(make_px(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        W_MAX, W_MAX, W_MAX, W_MAX));
        send_px(make_px(MODE_UNUSED, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                        W_ONE, 4660, 22136, 1));
    endtask

    // Triangular bins: first bins, last bin, ramp start, top code, alpha
    // rounding both ways, saturation. High bytes carry junk that must be ignored.
    task automatic test_tri_bin_codes();
        send_px(make_px(MODE_CODE, 16'hFF00, 16'hFF01, 16'h0002, 16'h8003,
                        65536, 32768, 16384, 8192));
        send_px(make_px(MODE_CODE, 16'h0068, 16'h5569, 16'hAA76, 16'h0177,
                        65536, 32768, 16384, 8192));
        send_px(make_px(MODE_CODE, 16'h0078, 16'hFF79, 16'h0080, 16'h00FF,
                        65536, 32768, 16384, 8192));
        send_px(make_px(MODE_CODE, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32768, 0, 0, 0));
        send_px(make_px(MODE_CODE, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32767, 0, 0, 0));
        send_px(make_px(MODE_CODE, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF,
                        W_MAX, W_MAX, W_MAX, W_MAX));
    endtask

    // Binary alpha scheme: transparent zero, ramp ends, rounding, saturation,
    // and a non-code mode to show the scheme has no effect there.
    task automatic test_bin_alpha_codes();
        write_scheme(CODE_BIN_ALPHA);
        send_px(make_px(MODE_CODE, 16'hFF00, 16'h0001, 16'h0002, 16'h00FF,
                        65536, 32768, 16384, 8192));
        send_px(make_px(MODE_CODE, 16'h007F, 16'h0080, 16'h00FD, 16'h00FE,
                        65536, 32768, 16384, 8192));
        send_px(make_px(MODE_CODE, 16'h0000, 16'h0001, 16'h0000, 16'h0000, W_ONE, 32768, 0, 0));
        send_px(make_px(MODE_CODE, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF,
                        W_MAX, W_MAX, W_MAX, W_MAX));
        send_px(make_px(MODE_LA, 16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00,
                        W_ONE, W_ONE, W_ONE, W_ONE));
    endtask

    // Random items under one scheme. Weights are bilinear sets half the time,
    // else free Q1.16 up to one, full 17-bit and corner values. Code bytes lean
    // toward the low bins and the ramp boundary.
    task automatic test_random_mix(input logic scheme, input int n_items);
        px_item_t        it;
        longint unsigned fx;
        longint unsigned fy;
        int              sel;
        write_scheme(scheme);
        repeat (n_items) begin
            sel = $urandom_range(0, 19);
            if (sel < 5)
                it.mode = MODE_LUM;
            else if (sel < 11)
                it.mode = MODE_LA;
            else if (sel < 18)
                it.mode = MODE_CODE;
            else
                it.mode = MODE_UNUSED;
            for (int i = 0; i < NUM_LANES; i++) begin
                it.texel[i] = TEXEL_W'($urandom());
                if (it.mode == MODE_CODE) begin
                    sel = $urandom_range(0, 9);
                    if (sel >= 8)
                        it.texel[i][7:0] = 8'($urandom_range(110, 130));
                    else if (sel >= 6)
                        it.texel[i][7:0] = 8'($urandom_range(0, 20));
                end
            end
            sel = $urandom_range(0, 19);
            if (sel < 10) begin
                fx = 64'($urandom_range(0, W_ONE));
                fy = 64'($urandom_range(0, W_ONE));
                it.weight[0] = (WFB + 1)'(((W_ONE - fx) * (W_ONE - fy)) >> WFB);
                it.weight[1] = (WFB + 1)'((fx * (W_ONE - fy)) >> WFB);
                it.weight[2] = (WFB + 1)'(((W_ONE - fx) * fy) >> WFB);
                it.weight[3] = (WFB + 1)'((fx * fy) >> WFB);
            end else begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    if (sel < 15)
                        it.weight[i] = (WFB + 1)'($urandom_range(0, W_ONE));
                    else if (sel < 18)
                        it.weight[i] = (WFB + 1)'($urandom());
                    else
                        case ($urandom_range(0, 2))
                            0:       it.weight[i] = '0;
                            1:       it.weight[i] = W_ONE;
                            default: it.weight[i] = W_MAX;
                        endcase
                end
            end
            send_px(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n               = 1'b0;
        px_if.valid         = 1'b0;
        px_if.mode          = MODE_LUM;
        px_if.texel_0       = '0;
        px_if.texel_1       = '0;
        px_if.texel_2       = '0;
        px_if.texel_3       = '0;
        px_if.weight_0      = '0;
        px_if.weight_1      = '0;
        px_if.weight_2      = '0;
        px_if.weight_3      = '0;
        res_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.code_version = CODE_TRI_BINS;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_plain_extremes();
        test_unused_mode();
        test_tri_bin_codes();
        test_bin_alpha_codes();
        test_random_mix(CODE_TRI_BINS, 500);
        test_random_mix(CODE_BIN_ALPHA, 500);
        test_random_mix(CODE_TRI_BINS, 500);

        // all results in, then wait on to catch anything extra
        drain_results();
        repeat (10) @(negedge clk);

        $display("Checked %0d results: %0d luminance, %0d lum+alpha, %0d unused-mode items",
                 n_checked, mode_seen[MODE_LUM], mode_seen[MODE_LA], mode_seen[MODE_UNUSED]);
        $display("Code items: %0d with triangular bins, %0d with binary alpha; %0d errors",
                 code_seen[CODE_TRI_BINS], code_seen[CODE_BIN_ALPHA], errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
